// ----- hdl/latent_median_quantizer_defines.svh -----
// assertion macros for the latent median quantizer
`ifndef LATENT_MEDIAN_QUANTIZER_DEFINES_SVH
`define LATENT_MEDIAN_QUANTIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define LMQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LMQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LMQ_ASSERT(label, clk, rst, prop, msg)
`define LMQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- hdl/lmq_pkg.sv -----
// ----------------------------------------------------------------------------
// lmq_pkg
// shared types and constants of the latent median quantizer
// ----------------------------------------------------------------------------
package lmq_pkg;
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_QUANTIZE = 1'b1;
  localparam int   STEP_W      = 24;
  localparam int   DIFF_W      = 33;
  localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;
  localparam logic [0:0] REG_STEP = 1'b0;

  // work handed from front to back
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic                     first;
  } job_t;

  // one result beat
  typedef struct packed {
    logic signed [31:0] symbol;
    logic               saturated;
    logic signed [31:0] running_min;
    logic signed [31:0] running_max;
    logic               fits_int16;
  } result_t;
endpackage

// ----- hdl/lmq_ram.sv -----
// ----------------------------------------------------------------------------
// lmq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/lmq_front.sv -----
// ----------------------------------------------------------------------------
// lmq_front
// accepts beats, keeps the median table, forms differences into a small queue
// ----------------------------------------------------------------------------
module lmq_front #(
  parameter int MAX_CHANNELS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               operation,
  input  logic [7:0]         channel,
  input  logic signed [31:0] sample_value,
  input  logic               first_of_tensor,
  output logic               job_valid,
  output lmq_pkg::job_t      job,
  input  logic               job_take
);
  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  // one bit above the table size so the range compare never wraps
  localparam int CHW = ((AW > 8) ? AW : 8) + 1;

  logic          accept;
  logic          in_range;
  logic [AW-1:0] addr;
  logic [31:0]   rdata;
  logic [CHW-1:0] ch_ext;

  // lookup stage
  logic               s1_valid;
  logic               s1_zero;
  logic signed [31:0] s1_value;
  logic               s1_first;

  // two entry queue
  lmq_pkg::job_t q [2];
  logic          wp, rp;
  logic [1:0]    cnt;

  assign ch_ext   = CHW'(channel);
  assign in_range = ch_ext < CHW'(MAX_CHANNELS);
  assign addr     = ch_ext[AW-1:0];
  // stall while a lookup plus the queue could overflow
  assign full     = (cnt + {1'b0, s1_valid}) >= 2'd2;
  assign accept   = push && !full;

  lmq_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_median (
    .clk(clk),
    .we(accept && operation == lmq_pkg::OP_LOAD && in_range),
    .waddr(addr), .wdata(sample_value), .raddr(addr), .rdata(rdata)
  );

  // lookup stage register
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= accept && operation == lmq_pkg::OP_QUANTIZE;
    s1_zero  <= !in_range;
    s1_value <= sample_value;
    s1_first <= first_of_tensor;
  end

  // queue of differences
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (s1_valid) begin
        q[wp].diff  <= 33'(s1_value) - (s1_zero ? 33'sd0 : 33'($signed(rdata)));
        q[wp].first <= s1_first;
        wp <= ~wp;
      end
      if (job_take) rp <= ~rp;
      cnt <= cnt + {1'b0, s1_valid} - {1'b0, job_take};
    end
  end

  assign job_valid = cnt != 2'd0;
  assign job       = q[rp];
endmodule

// ----- hdl/lmq_back.sv -----
// ----------------------------------------------------------------------------
// lmq_back
// restoring divider with half even rounding, saturation and min max tracking
// ----------------------------------------------------------------------------
module lmq_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lmq_pkg::STEP_W-1:0]    step_cfg,
  input  logic                          job_valid,
  input  lmq_pkg::job_t                 job,
  output logic                          job_take,
  output logic                          empty,
  input  logic                          pop,
  output lmq_pkg::result_t              result
);
  localparam int DW = lmq_pkg::DIFF_W;
  localparam int SW = lmq_pkg::STEP_W;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state;
  logic [5:0]    count;
  logic [DW-1:0] mag;
  logic [DW-1:0] quo;
  logic [SW:0]   rem;
  logic [SW-1:0] step;
  logic          neg, first;
  logic          out_valid;

  logic signed [31:0] min_so_far, max_so_far;

  logic [SW+1:0] trial;
  logic [SW:0]   rem_shift;
  logic          rnz;
  logic [SW+1:0] twice_r;
  logic          up;
  logic [DW:0]   qmag;
  logic signed [DW+1:0] q;
  logic signed [31:0]   sym;
  logic                 sat;
  logic signed [31:0]   nmin, nmax;

  // one quotient bit per cycle
  assign rem_shift = {rem[SW-1:0], mag[DW-1]};
  assign trial     = {1'b0, rem_shift} - {2'b0, step};

  // magnitude division gives trunc; floor and round from remainder
  always_comb begin
    rnz     = rem != '0;
    // floor remainder for negatives is step - rem
    twice_r = (neg && rnz) ? {({1'b0, step} - rem), 1'b0} : {rem, 1'b0};
    qmag    = {1'b0, quo};
    if (neg) begin
      // floor = -(quo + rnz)
      q = -$signed({1'b0, qmag + {{DW{1'b0}}, rnz}});
    end else begin
      q = $signed({1'b0, qmag});
    end
    up = (twice_r > {1'b0, step}) || ((twice_r == {1'b0, step}) && q[0]);
    q  = q + (DW+2)'(up);
    sat = 1'b0;
    if (q > (DW+2)'(64'sd2147483647)) begin
      sym = 32'sh7fffffff; sat = 1'b1;
    end else if (q < -(DW+2)'(64'sd2147483648)) begin
      sym = 32'sh80000000; sat = 1'b1;
    end else begin
      sym = q[31:0];
    end
    nmin = (first || sym < min_so_far) ? sym : min_so_far;
    nmax = (first || sym > max_so_far) ? sym : max_so_far;
  end

  assign job_take = (state == S_IDLE) && job_valid;
  assign empty    = !out_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      min_so_far <= 32'sh7fffffff; max_so_far <= 32'sh80000000;
    end else begin
      // result register: filled at rounding, emptied by pop
      if (state == S_FIN && (!out_valid || pop)) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (job_valid) begin
          neg   <= job.diff[DW-1];
          mag   <= job.diff[DW-1] ? DW'(-job.diff) : DW'(job.diff);
          first <= job.first;
          step  <= (step_cfg == '0) ? SW'(1) : step_cfg;
          rem   <= '0;
          quo   <= '0;
          count <= 6'(DW);
          state <= S_DIV;
        end
        S_DIV: begin
          if (trial[SW+1]) rem <= rem_shift;
          else rem <= trial[SW:0];
          quo   <= {quo[DW-2:0], ~trial[SW+1]};
          mag   <= {mag[DW-2:0], 1'b0};
          count <= count - 6'd1;
          if (count == 6'd1) state <= S_FIN;
        end
        S_FIN: if (!out_valid || pop) begin
          result.symbol      <= sym;
          result.saturated   <= sat;
          result.running_min <= nmin;
          result.running_max <= nmax;
          result.fits_int16  <= (nmin >= -32'sd32768) && (nmax <= 32'sd32767);
          min_so_far <= nmin; max_so_far <= nmax;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/latent_median_quantizer.sv -----
// ----------------------------------------------------------------------------
// latent_median_quantizer
// median subtract, exact divide by step, round half even, track min and max
// ----------------------------------------------------------------------------
// For a quantize beat the median is read at acceptance, the difference enters
// a two-entry queue in the next cycle, the back end loads its operands when it
// is idle, then runs bit-serial restoring division of the 33-bit magnitude and
// a rounding state. The back end works on one quantize beat at a time and takes
// the next only after rounding, which sets the rate, and an unpopped result
// holds it in the rounding state. Load beats write the median table and give no
// result. The front end keeps accepting beats while the divider works until
// the queue and its lookup stage hold two beats. The median table is not
// cleared after reset, so a channel must be loaded before its samples arrive.
module latent_median_quantizer #(
  parameter int MAX_CHANNELS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic               operation,
  input  logic [7:0]         channel,
  input  logic signed [31:0] sample_value,
  input  logic               first_of_tensor,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] symbol,
  output logic               saturated,
  output logic signed [31:0] running_min,
  output logic signed [31:0] running_max,
  output logic               fits_int16
);
`include "latent_median_quantizer_defines.svh"

  logic [lmq_pkg::STEP_W-1:0] step_cfg;
  logic             job_valid, job_take;
  lmq_pkg::job_t    job;
  lmq_pkg::result_t result;
  logic             sel0;
  logic             in_int16;

  // configuration register
  assign pready = 1'b1;
  assign sel0   = paddr[1:0] == {lmq_pkg::REG_STEP, 1'b0};
  always_ff @(posedge clk) begin
    if (rst) step_cfg <= lmq_pkg::STEP_RESET;
    else if (psel && penable && pwrite && sel0) step_cfg <= pwdata[23:0];
  end
  assign prdata = sel0 ? {8'd0, step_cfg} : 32'd0;

  lmq_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .channel(channel), .sample_value(sample_value),
    .first_of_tensor(first_of_tensor),
    .job_valid(job_valid), .job(job), .job_take(job_take)
  );

  lmq_back u_back (
    .clk(clk), .rst(rst), .step_cfg(step_cfg), .job_valid(job_valid),
    .job(job), .job_take(job_take), .empty(empty), .pop(pop), .result(result)
  );

  assign symbol      = result.symbol;
  assign saturated   = result.saturated;
  assign running_min = result.running_min;
  assign running_max = result.running_max;
  assign fits_int16  = result.fits_int16;

  // int16 range of the tracked extremes
  assign in_int16 = (running_min >= -32'sd32768) && (running_max <= 32'sd32767);

  // checks
  `LMQ_ASSERT(a_take_needs_valid, clk, rst, job_take |-> job_valid, "take without job")
  `LMQ_ASSERT(a_fit_flag, clk, rst, !empty |-> (fits_int16 == in_int16), "fit flag wrong")
  `LMQ_ASSERT(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(symbol)), "result lost")
endmodule
